// ===== sv/pixel_to_hex_cell_unit_macros.svh =====
// Assertion macros shared by the hex cell unit RTL.
`ifndef PIXEL_TO_HEX_CELL_UNIT_MACROS_SVH
`define PIXEL_TO_HEX_CELL_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/phc_pkg.sv =====
// Shared constants, types and helper functions of the hex cell unit.
package phc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XY_W      = 24;
    localparam int RAD_W     = 16;
    localparam int HEX_W     = 16;
    localparam int K_W       = FRAC_BITS;

    // numerator magnitude, signed numerator, products, rounding and cell widths
    localparam int MAG_W  = FRAC_BITS + XY_W - 1;
    localparam int NUM_W  = MAG_W + 1;
    localparam int PROD_W = K_W + 1 + XY_W;
    localparam int RND_W  = NUM_W + 2;
    localparam int N_W    = RND_W - FRAC_BITS;
    localparam int C_W    = N_W + 1;

    localparam logic [63:0] SQ3_Q32 = 64'd2479700524;
    localparam logic [K_W-1:0] K1 =
        K_W'((SQ3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam logic [K_W-1:0] K3 = K_W'(((64'd1 << FRAC_BITS) + 64'd1) / 3);
    localparam logic [K_W-1:0] K2 = K_W'(((64'd1 << (FRAC_BITS + 1)) + 64'd1) / 3);

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(8192);

    localparam logic signed [HEX_W-1:0] HEX_MAX = {1'b0, {(HEX_W-1){1'b1}}};
    localparam logic signed [HEX_W-1:0] HEX_MIN = {1'b1, {(HEX_W-1){1'b0}}};

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } div_arg_t;

    typedef struct packed {
        logic [MAG_W-1:0] quo;
        logic [RAD_W-1:0] rem;
        logic             neg;
    } div_res_t;

    typedef struct packed {
        logic signed [N_W-1:0]  n;
        logic [FRAC_BITS-1:0]   d;
    } rnd_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [HEX_W-1:0] v;
    } sat_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [HEX_W-1:0] r;
        logic signed [HEX_W-1:0] q;
    } hex_res_t;

    // Turn a sign/magnitude truncating quotient into a floor quotient.
    function automatic logic signed [NUM_W-1:0] floor_fix(div_res_t dr);
        logic [NUM_W-1:0] ext;
        ext = {1'b0, dr.quo};
        if (!dr.neg)
            return $signed(ext);
        else if (dr.rem != '0)
            return $signed(~ext);
        else
            return $signed(-ext);
    endfunction

    // Round half up to an integer and report the absolute rounding error.
    function automatic rnd_t round_fix(logic signed [RND_W-1:0] v);
        logic [RND_W-1:0]     sum;
        logic [FRAC_BITS-1:0] t;
        rnd_t                 res;
        sum   = v + RND_W'(HALF);
        t     = sum[FRAC_BITS-1:0];
        res.n = $signed(sum[RND_W-1:FRAC_BITS]);
        res.d = (t <= HALF) ? (HALF - t) : (t - HALF);
        return res;
    endfunction

    // Clamp to the 16-bit cell range.
    function automatic sat_t sat_hex(logic signed [C_W-1:0] v);
        sat_t res;
        if (v > C_W'(HEX_MAX)) begin
            res.v   = HEX_MAX;
            res.ovf = 1'b1;
        end
        else if (v < C_W'(HEX_MIN)) begin
            res.v   = HEX_MIN;
            res.ovf = 1'b1;
        end
        else begin
            res.v   = v[HEX_W-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== sv/phc_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module phc_div (
    input  logic              clk,
    input  logic              en,
    input  logic [phc_pkg::RAD_W-1:0] den,
    input  phc_pkg::div_arg_t arg,
    output phc_pkg::div_res_t res
);

    localparam int STAGES = phc_pkg::MAG_W;
    localparam int MAG_W  = phc_pkg::MAG_W;
    localparam int RAD_W  = phc_pkg::RAD_W;

    logic [MAG_W-1:0] w_lnk   [STAGES+1];
    logic [RAD_W-1:0] rem_lnk [STAGES+1];
    logic             neg_lnk [STAGES+1];

    assign w_lnk[0]   = arg.mag;
    assign rem_lnk[0] = '0;
    assign neg_lnk[0] = arg.neg;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [MAG_W-1:0] w_reg,   w_next;
        logic [RAD_W-1:0] rem_reg, rem_next;
        logic             neg_reg;
        logic [RAD_W:0]   trial;

        always_comb
        begin
            trial = {rem_lnk[i], w_lnk[i][MAG_W-1]};
            if (trial >= {1'b0, den})
            begin
                rem_next = RAD_W'(trial - {1'b0, den});
                w_next   = {w_lnk[i][MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[RAD_W-1:0];
                w_next   = {w_lnk[i][MAG_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg   <= w_next;
                rem_reg <= rem_next;
                neg_reg <= neg_lnk[i];
            end
        end

        assign w_lnk[i+1]   = w_reg;
        assign rem_lnk[i+1] = rem_reg;
        assign neg_lnk[i+1] = neg_reg;
    end

    assign res.quo = w_lnk[STAGES];
    assign res.rem = rem_lnk[STAGES];
    assign res.neg = neg_lnk[STAGES];

endmodule

// ===== sv/pixel_to_hex_cell_unit.sv =====
// Top level of the pixel to pointy-top hex cell unit (axial q, r out).
// Pipeline: 45 register stages from input to m_tvalid, 39 of them in the divider.
// Throughput: one item per cycle; the pipeline only halts while the skid register is full.
// Reset: rst_n clears all valid bits and loads cell_radius with 32.0 (8192).
// cfg writes are taken any cycle; write them only while the pipeline is empty.
`include "pixel_to_hex_cell_unit_macros.svh"

module pixel_to_hex_cell_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel: cell_radius
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // [23:0] world_x, [47:24] world_y
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] hex_q, [31:16] hex_r
    output logic [0:0]  m_tuser      // [0] overflow
);

    localparam int XY_W   = phc_pkg::XY_W;
    localparam int RAD_W  = phc_pkg::RAD_W;
    localparam int PROD_W = phc_pkg::PROD_W;
    localparam int NUM_W  = phc_pkg::NUM_W;
    localparam int MAG_W  = phc_pkg::MAG_W;
    localparam int RND_W  = phc_pkg::RND_W;
    localparam int C_W    = phc_pkg::C_W;

    // ------------------------------------------------------------------
    // Configuration: the radius register; zero acts as the smallest radius.
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] cell_radius_reg;
    logic [RAD_W-1:0] den;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_radius_reg <= phc_pkg::RAD_RESET;
        else if (cfg_valid && cfg_ready)
            cell_radius_reg <= cfg_data;
    end

    assign den = (cell_radius_reg == '0) ? RAD_W'(1) : cell_radius_reg;

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the skid register
    // holds an item. A full skid means the output register is stalled too.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic skid_valid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // ------------------------------------------------------------------
    // Stage A: the three constant multiplications.
    // ------------------------------------------------------------------
    logic signed [XY_W-1:0]   world_x;
    logic signed [XY_W-1:0]   world_y;
    logic signed [PROD_W-1:0] px_next, py3_next, py2_next;
    logic signed [PROD_W-1:0] px_reg,  py3_reg,  py2_reg;
    logic                     a_valid_reg;

    assign world_x  = s_tdata[23:0];
    assign world_y  = s_tdata[47:24];
    assign px_next  = $signed({1'b0, phc_pkg::K1}) * world_x;
    assign py3_next = $signed({1'b0, phc_pkg::K3}) * world_y;
    assign py2_next = $signed({1'b0, phc_pkg::K2}) * world_y;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            px_reg  <= px_next;
            py3_reg <= py3_next;
            py2_reg <= py2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: form both numerators and split them into sign and magnitude.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] diff_q;
    logic signed [NUM_W-1:0]  num_q, num_r;
    phc_pkg::div_arg_t        argq_next, argr_next;
    phc_pkg::div_arg_t        argq_reg,  argr_reg;
    logic                     b_valid_reg;

    assign diff_q = px_reg - py3_reg;
    assign num_q  = diff_q[NUM_W-1:0];
    assign num_r  = py2_reg[NUM_W-1:0];

    always_comb
    begin
        argq_next.neg = num_q[NUM_W-1];
        argq_next.mag = num_q[NUM_W-1] ? MAG_W'(-num_q) : num_q[MAG_W-1:0];
        argr_next.neg = num_r[NUM_W-1];
        argr_next.mag = num_r[NUM_W-1] ? MAG_W'(-num_r) : num_r[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            argq_reg <= argq_next;
            argr_reg <= argr_next;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: both axes run side by side; the valid bit rides alongside.
    // ------------------------------------------------------------------
    phc_pkg::div_res_t divq_res, divr_res;
    logic [MAG_W-1:0]  dv_reg;

    phc_div u_divq (
        .clk (clk),
        .en  (pipe_en),
        .den (den),
        .arg (argq_reg),
        .res (divq_res)
    );

    phc_div u_divr (
        .clk (clk),
        .en  (pipe_en),
        .den (den),
        .arg (argr_reg),
        .res (divr_res)
    );

    // ------------------------------------------------------------------
    // Stage F1: floor the quotients.
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] qf_reg, rf_reg;
    logic                    f1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            qf_reg <= phc_pkg::floor_fix(divq_res);
            rf_reg <= phc_pkg::floor_fix(divr_res);
        end
    end

    // ------------------------------------------------------------------
    // Stage F2: derive s and round all three axes half up.
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0] qx, rx, sx;
    phc_pkg::rnd_t           rq_reg, rr_reg, rs_reg;
    logic                    f2_valid_reg;

    assign qx = RND_W'(qf_reg);
    assign rx = RND_W'(rf_reg);
    assign sx = -qx - rx;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rq_reg <= phc_pkg::round_fix(qx);
            rr_reg <= phc_pkg::round_fix(rx);
            rs_reg <= phc_pkg::round_fix(sx);
        end
    end

    // ------------------------------------------------------------------
    // Stage F3: rebuild the axis with the largest error, then saturate.
    // Ties fall through to the next test, so r wins a tie with q and s wins any tie.
    // ------------------------------------------------------------------
    logic signed [C_W-1:0] cq, cr, cs, q_fix, r_fix;
    phc_pkg::sat_t         sat_q, sat_r;
    phc_pkg::hex_res_t     res_next, res_reg;
    logic                  res_valid_reg;

    assign cq = C_W'(rq_reg.n);
    assign cr = C_W'(rr_reg.n);
    assign cs = C_W'(rs_reg.n);

    always_comb
    begin
        q_fix = cq;
        r_fix = cr;
        if (rq_reg.d > rr_reg.d && rq_reg.d > rs_reg.d)
            q_fix = -cr - cs;
        else if (rr_reg.d > rs_reg.d)
            r_fix = -cq - cs;
        sat_q        = phc_pkg::sat_hex(q_fix);
        sat_r        = phc_pkg::sat_hex(r_fix);
        res_next.q   = sat_q.v;
        res_next.r   = sat_r.v;
        res_next.ovf = sat_q.ovf | sat_r.ovf;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            res_reg <= res_next;
    end

    // Valid bits of every stage; they clear on reset and advance with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            dv_reg        <= '0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_valid_reg   <= s_tvalid;
            b_valid_reg   <= a_valid_reg;
            dv_reg        <= {dv_reg[MAG_W-2:0], b_valid_reg};
            f1_valid_reg  <= dv_reg[MAG_W-1];
            f2_valid_reg  <= f1_valid_reg;
            res_valid_reg <= f2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid register. The skid catches the item that
    // leaves the pipeline in the cycle the output stalls; while it is full
    // the pipeline holds, and it drains into the output once taken.
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    phc_pkg::hex_res_t out_reg, skid_reg;
    logic              out_load, skid_load;

    assign out_load  = skid_valid_reg ? m_tready : (!out_valid_reg || m_tready);
    assign skid_load = !skid_valid_reg && out_valid_reg && !m_tready && res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_tready)
                    skid_valid_reg <= 1'b0;
            end
            else if (out_load)
                out_valid_reg <= res_valid_reg;
            else if (skid_load)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        if (skid_load)
            skid_reg <= res_reg;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg.r, out_reg.q};
    assign m_tuser[0] = out_reg.ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PHC_ASSERT_NOW(a_skid_implies_out, skid_valid_reg, out_valid_reg,
        "skid holds an item while the output register is empty")
    `PHC_ASSERT_NOW(a_skid_fill_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg && !m_tready && res_valid_reg),
        "skid filled without a stalled output and a finished item")
    `PHC_ASSERT_NOW(a_ovf_at_bound, out_valid_reg && out_reg.ovf,
        out_reg.q == phc_pkg::HEX_MAX || out_reg.q == phc_pkg::HEX_MIN ||
        out_reg.r == phc_pkg::HEX_MAX || out_reg.r == phc_pkg::HEX_MIN,
        "overflow flagged but neither coordinate sits at a bound")
    `PHC_ASSERT_NEXT(a_stall_holds_result, !pipe_en && res_valid_reg,
        res_valid_reg && $stable(res_reg),
        "finished item changed while the pipeline was halted")

endmodule
